// ----- rtl/core/scma_pkg.sv -----
// Package with the shared types, constants and arithmetic of the CSC assembly engine.
package scma_pkg;

    localparam int MaxEquations = 1024;
    localparam int MaxNonzeros  = 16384;
    localparam int FracBits     = 16;

    localparam int EqW   = $clog2(MaxEquations);
    localparam int NzW   = $clog2(MaxNonzeros);
    localparam int PosW  = 15;
    localparam int ColW  = 12;
    localparam int RowW  = 11;

    typedef enum logic [2:0] {
        MODE_LOAD_START = 3'd0,
        MODE_LOAD_ROW   = 3'd1,
        MODE_ADD_MAT    = 3'd2,
        MODE_ADD_RHS    = 3'd3,
        MODE_READ_MAT   = 3'd4,
        MODE_READ_RHS   = 3'd5,
        MODE_CLR_MAT    = 3'd6,
        MODE_CLR_RHS    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_RANGE   = 2'd1,
        ST_MISSING = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    localparam logic [1:0] REG_NEQ = 2'd0;
    localparam logic [1:0] REG_SYM = 2'd1;
    localparam logic [1:0] REG_NNZ = 2'd2;

    // Rounds a product to FracBits fraction bits (ties up) and adds it with saturation.
    function automatic logic [32:0] round_add(input logic signed [63:0] prod,
                                              input logic signed [31:0] acc);
        logic signed [63:0] rnd;
        logic signed [65:0] sum;
        logic [32:0] res;
        begin
            if (FracBits > 0) rnd = (prod + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
            else rnd = prod;
            sum = 66'(rnd) + 66'(acc);
            if (sum > 66'sd2147483647) res = {1'b1, 32'h7FFF_FFFF};
            else if (sum < -66'sd2147483648) res = {1'b1, 32'h8000_0000};
            else res = {1'b0, sum[31:0]};
            return res;
        end
    endfunction

endpackage

// ----- rtl/core/scma_struct_mem.sv -----
// Structure memories: column start pointers and per-slot row indices.
module scma_struct_mem
    import scma_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_cs_we,
    input  logic [EqW:0]    i_cs_waddr,
    input  logic [PosW-1:0] i_cs_wdata,
    input  logic [EqW:0]    i_cs_raddr,
    output logic [PosW-1:0] o_cs_rdata,
    input  logic            i_ri_we,
    input  logic [NzW-1:0]  i_ri_waddr,
    input  logic [EqW-1:0]  i_ri_wdata,
    input  logic [NzW-1:0]  i_ri_raddr,
    output logic [EqW-1:0]  o_ri_rdata
);

    logic [PosW-1:0] r_cs_mem [MaxEquations+1];
    logic [EqW-1:0]  r_ri_mem [MaxNonzeros];

    always_ff @(posedge i_clk) begin
        if (i_cs_we) begin
            r_cs_mem[i_cs_waddr] <= i_cs_wdata;
        end
        o_cs_rdata <= r_cs_mem[i_cs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ri_we) begin
            r_ri_mem[i_ri_waddr] <= i_ri_wdata;
        end
        o_ri_rdata <= r_ri_mem[i_ri_raddr];
    end

endmodule

// ----- rtl/core/scma_value_mem.sv -----
// Value memories: matrix slot values and right-hand-side entries.
module scma_value_mem
    import scma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_mv_we,
    input  logic [NzW-1:0]    i_mv_addr,
    input  logic [31:0]       i_mv_wdata,
    output logic [31:0]       o_mv_rdata,
    input  logic              i_rv_we,
    input  logic [EqW-1:0]    i_rv_addr,
    input  logic [31:0]       i_rv_wdata,
    output logic [31:0]       o_rv_rdata
);

    logic [31:0] r_mv_mem [MaxNonzeros];
    logic [31:0] r_rv_mem [MaxEquations];

    always_ff @(posedge i_clk) begin
        if (i_mv_we) begin
            r_mv_mem[i_mv_addr] <= i_mv_wdata;
        end
        o_mv_rdata <= r_mv_mem[i_mv_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_rv_we) begin
            r_rv_mem[i_rv_addr] <= i_rv_wdata;
        end
        o_rv_rdata <= r_rv_mem[i_rv_addr];
    end

endmodule

// ----- rtl/core/sparse_csc_matrix_accumulate.sv -----
// Top level of the CSC assembly engine: register port, sequencer and result register.
// A matrix add reads its column's start and end pointers, then walks the slots of that column
// one by one; loads, reads and rejected items skip the walk. Clears zero one entry per step.
// One item is worked at a time; the next is taken as soon as the result leaves the core.
// Reset (synchronous, active low) clears registers; then a clearing pass zeroes both value
// stores before the first item is taken.
module sparse_csc_matrix_accumulate
    import scma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_mode,
    input  logic signed [10:0]  i_row,
    input  logic signed [11:0]  i_col,
    input  logic [14:0]         i_position,
    input  logic signed [31:0]  i_value,
    input  logic signed [31:0]  i_scale,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_read_value,
    output logic [1:0]          o_status
);

    // Configuration registers.
    logic [10:0] r_neq;
    logic        r_sym;
    logic [14:0] r_nnz;
    logic [1:0]  w_ridx;
    assign pready = 1'b1;
    assign w_ridx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neq <= '0;
            r_sym <= 1'b0;
            r_nnz <= '0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (w_ridx)
                REG_NEQ: r_neq <= pwdata[10:0];
                REG_SYM: r_sym <= pwdata[0];
                REG_NNZ: r_nnz <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (w_ridx)
                REG_NEQ: prdata = {21'd0, r_neq};
                REG_SYM: prdata = {31'd0, r_sym};
                REG_NNZ: prdata = {17'd0, r_nnz};
                default: prdata = '0;
            endcase
        end
    end

    // Effective equation count, capped at MaxEquations.
    logic [EqW:0] w_size;
    assign w_size = (r_neq > 11'(MaxEquations)) ? (EqW+1)'(MaxEquations) : r_neq[EqW:0];

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CS0, S_CS1, S_WALK, S_MUL, S_ACC, S_RD, S_CLR, S_OUT
    } t_state;

    t_state             r_state;
    t_mode              r_mode;
    logic [EqW-1:0]     r_row;
    logic [EqW:0]       r_col;
    logic [PosW-1:0]    r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_scl;
    logic [PosW-1:0]    r_k;
    logic [PosW-1:0]    r_end;
    logic [NzW:0]       r_cnt;
    logic [NzW:0]       r_lim;
    logic               r_walk_vld;
    logic signed [63:0] r_prod;
    logic               r_tgt_rhs;
    logic [1:0]         r_st;

    // Memory ports.
    logic            w_cs_we, w_ri_we, w_mv_we, w_rv_we;
    logic [EqW:0]    w_cs_waddr, w_cs_raddr;
    logic [PosW-1:0] w_cs_rdata;
    logic [NzW-1:0]  w_ri_waddr, w_ri_raddr, w_mv_addr;
    logic [EqW-1:0]  w_ri_rdata, w_rv_addr;
    logic [31:0]     w_mv_wdata, w_rv_wdata, w_mv_rdata, w_rv_rdata;

    scma_struct_mem u_struct (
        .i_clk      (i_clk),
        .i_cs_we    (w_cs_we),
        .i_cs_waddr (w_cs_waddr),
        .i_cs_wdata (i_position),
        .i_cs_raddr (w_cs_raddr),
        .o_cs_rdata (w_cs_rdata),
        .i_ri_we    (w_ri_we),
        .i_ri_waddr (w_ri_waddr),
        .i_ri_wdata (i_row[EqW-1:0]),
        .i_ri_raddr (w_ri_raddr),
        .o_ri_rdata (w_ri_rdata)
    );

    scma_value_mem u_value (
        .i_clk      (i_clk),
        .i_mv_we    (w_mv_we),
        .i_mv_addr  (w_mv_addr),
        .i_mv_wdata (w_mv_wdata),
        .o_mv_rdata (w_mv_rdata),
        .i_rv_we    (w_rv_we),
        .i_rv_addr  (w_rv_addr),
        .i_rv_wdata (w_rv_wdata),
        .o_rv_rdata (w_rv_rdata)
    );

    logic w_acc;
    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    // Input range checks, done on the live item in the accept cycle.
    logic w_row_ok, w_col_ok, w_ld_col_ok, w_pos_ok, w_upper;
    assign w_row_ok    = !i_row[10] && ({1'b0, i_row} < 12'(w_size));
    assign w_col_ok    = !i_col[11] && (i_col < 12'(w_size));
    assign w_ld_col_ok = !i_col[11] && (i_col <= 12'(MaxEquations));
    assign w_pos_ok    = i_position < 15'(MaxNonzeros);
    assign w_upper     = r_sym && (i_row < 11'(i_col));

    // Walk: slot k is read this cycle, its row index seen the next.
    logic w_k_live;
    assign w_k_live = (r_k < r_end);
    logic [32:0] w_sum;
    assign w_sum = round_add(r_prod, r_tgt_rhs ? w_rv_rdata : w_mv_rdata);

    always_comb begin
        w_cs_we    = w_acc && i_mode == MODE_LOAD_START && w_ld_col_ok;
        w_cs_waddr = i_col[EqW:0];
        w_cs_raddr = (r_state == S_IDLE) ? i_col[EqW:0] : r_col + 1'b1;
        w_ri_we    = w_acc && i_mode == MODE_LOAD_ROW && w_pos_ok && !i_row[10] &&
                     ({1'b0, i_row} < 12'(MaxEquations));
        w_ri_waddr = i_position[NzW-1:0];
        w_ri_raddr = r_k[NzW-1:0];
        w_mv_we    = 1'b0;
        w_mv_wdata = '0;
        w_mv_addr  = r_k[NzW-1:0];
        w_rv_we    = 1'b0;
        w_rv_wdata = '0;
        w_rv_addr  = r_row;
        case (r_state)
            S_INIT: begin
                w_mv_we = 1'b1;
                w_mv_addr = r_cnt[NzW-1:0];
                w_rv_we = 1'b1;
                w_rv_addr = r_cnt[EqW-1:0];
            end
            S_IDLE: begin
                w_mv_addr = i_position[NzW-1:0];
                w_rv_addr = i_row[EqW-1:0];
            end
            // The read address is held while the result waits, so the data stays valid.
            S_RD, S_OUT: w_mv_addr = r_pos[NzW-1:0];
            S_ACC: begin
                w_mv_we = !r_tgt_rhs;
                w_rv_we = r_tgt_rhs;
                w_mv_wdata = w_sum[31:0];
                w_rv_wdata = w_sum[31:0];
            end
            S_CLR: begin
                w_mv_we = (r_mode == MODE_CLR_MAT) && r_cnt < r_lim;
                w_rv_we = (r_mode == MODE_CLR_RHS) && r_cnt < r_lim;
                w_mv_addr = r_cnt[NzW-1:0];
                w_rv_addr = r_cnt[EqW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (NzW+1)'(MaxNonzeros - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (w_acc) begin
                    r_mode <= t_mode'(i_mode);
                    r_row  <= i_row[EqW-1:0];
                    r_col  <= i_col[EqW:0];
                    r_pos  <= i_position;
                    r_val  <= i_value;
                    r_scl  <= i_scale;
                    r_st   <= ST_DONE;
                    r_cnt  <= '0;
                    r_state <= S_OUT;
                    case (t_mode'(i_mode))
                        MODE_LOAD_START: if (!w_ld_col_ok) r_st <= ST_RANGE;
                        MODE_LOAD_ROW: if (!w_ri_we) r_st <= ST_RANGE;
                        MODE_ADD_MAT: begin
                            if (i_scale == 0) r_state <= S_OUT;
                            else if (!w_row_ok || !w_col_ok || w_upper) r_st <= ST_RANGE;
                            else r_state <= S_CS0;
                        end
                        MODE_ADD_RHS: begin
                            r_tgt_rhs <= 1'b1;
                            if (i_scale == 0) r_state <= S_OUT;
                            else if (!w_row_ok) r_st <= ST_RANGE;
                            else r_state <= S_MUL;
                        end
                        MODE_READ_MAT: begin
                            if (!w_pos_ok) r_st <= ST_RANGE;
                            else r_state <= S_RD;
                        end
                        MODE_READ_RHS: begin
                            if (!w_row_ok) r_st <= ST_RANGE;
                            else r_state <= S_RD;
                        end
                        MODE_CLR_MAT: begin
                            r_lim <= (r_nnz > 15'(MaxNonzeros)) ? (NzW+1)'(MaxNonzeros)
                                                                : r_nnz[NzW:0];
                            r_state <= S_CLR;
                        end
                        default: begin
                            r_lim <= (NzW+1)'(w_size);
                            r_state <= S_CLR;
                        end
                    endcase
                end
                S_CS0: begin
                    // Start pointer arrives; end pointer is being read.
                    r_k <= w_cs_rdata;
                    r_tgt_rhs <= 1'b0;
                    r_state <= S_CS1;
                end
                S_CS1: begin
                    r_end <= (w_cs_rdata > 15'(MaxNonzeros)) ? 15'(MaxNonzeros) : w_cs_rdata;
                    r_walk_vld <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // r_walk_vld marks that the slot at r_k-1 was read last cycle.
                    if (r_walk_vld && w_ri_rdata == r_row) begin
                        r_k <= r_k - 1'b1;
                        r_state <= S_MUL;
                    end else if (!w_k_live) begin
                        r_st <= ST_MISSING;
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_walk_vld <= 1'b1;
                    end
                end
                S_MUL: begin
                    // Product registered; the target entry is read meanwhile.
                    r_prod <= 64'(r_val) * 64'(r_scl);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_sum[32]) r_st <= ST_SAT;
                    r_state <= S_OUT;
                end
                S_RD: r_state <= S_OUT;
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt >= r_lim) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && !(r_state == S_OUT)) o_valid <= 1'b0;
        end
    end

    // Output register: loaded when a result leaves the core.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!o_valid || i_ready)) begin
            o_status <= r_st;
            if (r_mode == MODE_READ_MAT && r_st == ST_DONE) o_read_value <= w_mv_rdata;
            else if (r_mode == MODE_READ_RHS && r_st == ST_DONE) o_read_value <= w_rv_rdata;
            else o_read_value <= '0;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("item taken while busy");
    a_sat_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && w_sum[32]) |=> (r_st == ST_SAT)) else $error("saturation lost");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !w_k_live && !r_walk_vld) |=> (r_state == S_OUT))
        else $error("walk ran past column end");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("result dropped");

endmodule
